// File: rtl/csus_pkg.sv
// Package: shared types, register indexes and constants for the CAN signal decoder.
`timescale 1ns / 1ps
`default_nettype none

package csus_pkg;

  localparam int FRAME_BYTES_DEF = 8;
  localparam int FRAME_BITS      = 64;
  localparam int MAX_SIG_BITS    = 32;
  localparam int RAW_W           = 33;
  localparam int SCALE_W         = 32;
  localparam int OFFSET_W        = 48;
  localparam int PHYS_W          = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 48;
  localparam int OUT_TDATA_W     = 104;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BIT  = 3'd0,
    REG_BIT_LENGTH = 3'd1,
    REG_BIG_ENDIAN = 3'd2,
    REG_IS_SIGNED  = 3'd3,
    REG_SCALE      = 3'd4,
    REG_OFFSET     = 3'd5
  } reg_idx_e;

  // Layout settings used by the bit extraction stages
  typedef struct packed {
    logic [5:0] start_bit;
    logic [5:0] bit_length;
    logic       big_endian;
    logic       is_signed;
  } ext_cfg_t;

  // Arithmetic settings used by the scaling stages
  typedef struct packed {
    logic signed [SCALE_W-1:0]  scale_q16;
    logic signed [OFFSET_W-1:0] offset_q16;
  } scl_cfg_t;

endpackage

`default_nettype wire

// File: rtl/csus_extract.sv
// Bit extraction pipeline: frame masking, field shift, orientation and sign extension.
`timescale 1ns / 1ps
`default_nettype none

module csus_extract #(
  parameter int FRAME_BYTES = csus_pkg::FRAME_BYTES_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  csus_pkg::ext_cfg_t                   cfg,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [csus_pkg::FRAME_BITS-1:0]      in_frame,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [csus_pkg::RAW_W-1:0]    out_raw
);

  localparam int FB = csus_pkg::FRAME_BITS;
  localparam int SW = csus_pkg::MAX_SIG_BITS;

  // stage A: masked frame, bytes bit-reversed for Motorola layout
  logic          a_valid_r, a_valid_nxt;
  logic [FB-1:0] a_frame_r, a_frame_nxt;
  // stage B: field bits aligned at bit 0, trimmed to length
  logic          b_valid_r, b_valid_nxt;
  logic [SW-1:0] b_bits_r, b_bits_nxt;
  // stage C: raw value
  logic                                 c_valid_r, c_valid_nxt;
  logic signed [csus_pkg::RAW_W-1:0]    c_raw_r, c_raw_nxt;

  logic          a_ready, b_ready, c_ready;
  logic [FB-1:0] byte_mask, masked, swapped;
  logic [5:0]    len, msb_lin, shamt, rshift;
  logic [SW:0]   one_sh;
  logic [SW-1:0] len_mask, shifted, rev, u;
  logic          sign_bit;

  assign c_ready  = !c_valid_r || out_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  // clamp length, map Motorola start bit to linear numbering
  assign len     = (cfg.bit_length > 6'(SW)) ? 6'(SW) : cfg.bit_length;
  assign msb_lin = {cfg.start_bit[5:3], ~cfg.start_bit[2:0]};
  assign shamt   = cfg.big_endian ? msb_lin : cfg.start_bit;
  assign one_sh  = (SW+1)'(1) << len;
  assign len_mask = SW'(one_sh - (SW+1)'(1));
  assign rshift  = 6'(SW) - len;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      byte_mask[8*k +: 8] = (k < FRAME_BYTES) ? 8'hFF : 8'h00;
    end
    masked = in_frame & byte_mask;
    for (int i = 0; i < FB; i++) begin
      swapped[i] = masked[(i & ~7) | (7 - (i & 7))];
    end
  end

  assign shifted = SW'(a_frame_r >> shamt);

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      rev[i] = b_bits_r[SW-1-i];
    end
    u        = cfg.big_endian ? (rev >> rshift) : b_bits_r;
    sign_bit = cfg.is_signed && (|(u & SW'(one_sh >> 1)));
  end

  always_comb begin
    a_valid_nxt = a_ready ? in_valid : a_valid_r;
    a_frame_nxt = (a_ready && in_valid) ? (cfg.big_endian ? swapped : masked) : a_frame_r;
    b_valid_nxt = b_ready ? a_valid_r : b_valid_r;
    b_bits_nxt  = (b_ready && a_valid_r) ? (shifted & len_mask) : b_bits_r;
    c_valid_nxt = c_ready ? b_valid_r : c_valid_r;
    if (c_ready && b_valid_r) begin
      c_raw_nxt = sign_bit ? ({1'b0, u} - one_sh) : {1'b0, u};
    end else begin
      c_raw_nxt = c_raw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_frame_r <= a_frame_nxt;
    b_bits_r  <= b_bits_nxt;
    c_raw_r   <= c_raw_nxt;
  end

  assign out_valid = c_valid_r;
  assign out_raw   = c_raw_r;

  // refusing input means every stage is occupied
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (a_valid_r && b_valid_r && c_valid_r && !out_ready))
    else $error("extract refused input with a free stage");

endmodule

`default_nettype wire

// File: rtl/csus_scale.sv
// Scaling pipeline: raw times factor, then offset add with saturation.
`timescale 1ns / 1ps
`default_nettype none

module csus_scale (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  csus_pkg::scl_cfg_t                   cfg,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  signed [csus_pkg::RAW_W-1:0]    in_raw,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [csus_pkg::RAW_W-1:0]    out_raw,
  output logic signed [csus_pkg::PHYS_W-1:0]   out_phys,
  output logic                                 out_sat
);

  localparam int PW = csus_pkg::PHYS_W;
  localparam int RW = csus_pkg::RAW_W;
  localparam int OW = csus_pkg::OFFSET_W;

  // stage D: product
  logic                 d_valid_r, d_valid_nxt;
  logic signed [RW-1:0] d_raw_r, d_raw_nxt;
  logic signed [PW-1:0] d_prod_r, d_prod_nxt;
  // stage E: output register
  logic                 e_valid_r, e_valid_nxt;
  logic signed [RW-1:0] e_raw_r, e_raw_nxt;
  logic signed [PW-1:0] e_phys_r, e_phys_nxt;
  logic                 e_sat_r, e_sat_nxt;

  logic                 d_ready, e_ready;
  logic signed [PW:0]   prod_full;
  logic [PW:0]          sum;
  logic [PW-1:0]        sat_val;
  logic                 ovf;

  assign e_ready  = !e_valid_r || out_ready;
  assign d_ready  = !d_valid_r || e_ready;
  assign in_ready = d_ready;

  assign prod_full = in_raw * cfg.scale_q16;

  // 65-bit sum; top two bits differ on overflow
  assign sum     = {d_prod_r[PW-1], d_prod_r} + {{(PW+1-OW){cfg.offset_q16[OW-1]}}, cfg.offset_q16};
  assign ovf     = sum[PW] ^ sum[PW-1];
  assign sat_val = sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};

  always_comb begin
    d_valid_nxt = d_ready ? in_valid : d_valid_r;
    d_raw_nxt   = (d_ready && in_valid) ? in_raw : d_raw_r;
    d_prod_nxt  = (d_ready && in_valid) ? prod_full[PW-1:0] : d_prod_r;
    e_valid_nxt = e_ready ? d_valid_r : e_valid_r;
    if (e_ready && d_valid_r) begin
      e_raw_nxt  = d_raw_r;
      e_phys_nxt = ovf ? sat_val : sum[PW-1:0];
      e_sat_nxt  = ovf;
    end else begin
      e_raw_nxt  = e_raw_r;
      e_phys_nxt = e_phys_r;
      e_sat_nxt  = e_sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      d_valid_r <= d_valid_nxt;
      e_valid_r <= e_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_raw_r  <= d_raw_nxt;
    d_prod_r <= d_prod_nxt;
    e_raw_r  <= e_raw_nxt;
    e_phys_r <= e_phys_nxt;
    e_sat_r  <= e_sat_nxt;
  end

  assign out_valid = e_valid_r;
  assign out_raw   = e_raw_r;
  assign out_phys  = e_phys_r;
  assign out_sat   = e_sat_r;

  a_blocked_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (d_valid_r && e_valid_r && !out_ready))
    else $error("scale refused input with a free stage");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (e_valid_r && e_sat_r) |->
      (e_phys_r == {1'b1, {(PW-1){1'b0}}} || e_phys_r == {1'b0, {(PW-1){1'b1}}}))
    else $error("saturation flag without a clipped value");

endmodule

`default_nettype wire

// File: rtl/can_signal_unpack_scale.sv
// Top level: CAN payload signal decoder with config registers and a 5-stage pipeline.
// Pipeline: five register stages
//   (mask, field shift, orient/sign, multiply, offset/saturate as the output register).
// Throughput: one item per cycle; a stage stalls only when it and all later stages are full.
// Reset: rst_n synchronous, active low; clears all valid bits and loads start 0, length 8,
//   Intel, unsigned, scale 1.0 and offset 0 into the config registers.
`timescale 1ns / 1ps
`default_nettype none

module can_signal_unpack_scale #(
  parameter int FRAME_BYTES = csus_pkg::FRAME_BYTES_DEF   // payload bytes present, 1..8
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // configuration write channel
  input  wire                                     cfg_valid,
  output logic                                    cfg_ready,
  input  wire  [csus_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  [csus_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input channel
  input  wire                                     in_tvalid,
  output logic                                    in_tready,
  input  wire  [csus_pkg::FRAME_BITS-1:0]         in_tdata,   // [63:0] frame_bytes
  // result channel
  output logic                                    out_tvalid,
  input  wire                                     out_tready,
  output logic [csus_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [32:0] raw_value,
                                                              // [96:33] physical_value,
                                                              // [103:97] zero
  output logic                                    out_tuser   // [0] saturated
);

  localparam int RW = csus_pkg::RAW_W;
  localparam int PW = csus_pkg::PHYS_W;

  // config registers
  logic [5:0]                         start_bit_r, start_bit_nxt;
  logic [5:0]                         bit_length_r, bit_length_nxt;
  logic                               big_endian_r, big_endian_nxt;
  logic                               is_signed_r, is_signed_nxt;
  logic [csus_pkg::SCALE_W-1:0]       scale_r, scale_nxt;
  logic [csus_pkg::OFFSET_W-1:0]      offset_r, offset_nxt;

  csus_pkg::ext_cfg_t                 ext_cfg;
  csus_pkg::scl_cfg_t                 scl_cfg;

  logic                               mid_valid, mid_ready;
  logic signed [RW-1:0]               mid_raw;
  logic signed [RW-1:0]               res_raw;
  logic signed [PW-1:0]               res_phys;
  logic                               cfg_wr;

  // registers are always writable; the user keeps the pipeline idle around writes
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    start_bit_nxt  = start_bit_r;
    bit_length_nxt = bit_length_r;
    big_endian_nxt = big_endian_r;
    is_signed_nxt  = is_signed_r;
    scale_nxt      = scale_r;
    offset_nxt     = offset_r;
    if (cfg_wr) begin
      case (cfg_index)
        csus_pkg::REG_START_BIT:  start_bit_nxt  = cfg_data[5:0];
        csus_pkg::REG_BIT_LENGTH: bit_length_nxt = cfg_data[5:0];
        csus_pkg::REG_BIG_ENDIAN: big_endian_nxt = cfg_data[0];
        csus_pkg::REG_IS_SIGNED:  is_signed_nxt  = cfg_data[0];
        csus_pkg::REG_SCALE:      scale_nxt      = cfg_data[csus_pkg::SCALE_W-1:0];
        csus_pkg::REG_OFFSET:     offset_nxt     = cfg_data[csus_pkg::OFFSET_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_bit_r  <= 6'd0;
      bit_length_r <= 6'd8;
      big_endian_r <= 1'b0;
      is_signed_r  <= 1'b0;
      scale_r      <= 32'h0001_0000;   // 1.0 in Q16.16
      offset_r     <= '0;
    end else begin
      start_bit_r  <= start_bit_nxt;
      bit_length_r <= bit_length_nxt;
      big_endian_r <= big_endian_nxt;
      is_signed_r  <= is_signed_nxt;
      scale_r      <= scale_nxt;
      offset_r     <= offset_nxt;
    end
  end

  assign ext_cfg.start_bit  = start_bit_r;
  assign ext_cfg.bit_length = bit_length_r;
  assign ext_cfg.big_endian = big_endian_r;
  assign ext_cfg.is_signed  = is_signed_r;
  assign scl_cfg.scale_q16  = scale_r;
  assign scl_cfg.offset_q16 = offset_r;

  // stages A..C: pull the signal out of the payload
  csus_extract #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_extract (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (ext_cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_frame  (in_tdata),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_raw   (mid_raw)
  );

  // stages D..E: scale, add offset, saturate; stage E is the output register
  csus_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (scl_cfg),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_raw    (mid_raw),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_raw   (res_raw),
    .out_phys  (res_phys),
    .out_sat   (out_tuser)
  );

  // pack result fields, raw first, pad to whole bytes
  assign out_tdata = {{(csus_pkg::OUT_TDATA_W - RW - PW){1'b0}}, res_phys, res_raw};

  a_len_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_index == csus_pkg::REG_BIT_LENGTH) |=> bit_length_r == $past(cfg_data[5:0]))
    else $error("bit length register missed a write");

endmodule

`default_nettype wire
